>>> rtl/tcbh_pkg.sv
package tcbh_pkg;

	localparam int KEY_W     = 31;
	localparam int VAL_W     = 32;
	localparam int PAIR_W    = KEY_W + VAL_W;
	localparam int STAT_W    = 3;
	localparam int USED_W    = 10;
	localparam int CNTO_W    = 13;
	localparam int CAPO_W    = 11;
	localparam int LOAD_W    = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 12;

	localparam int INIT_CAP_RST = 16;
	localparam int LOAD_MAX_RST = 192;

	localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd1;
	localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_MAX = 2'd1;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV1,
		ST_DIV2,
		ST_RF1,
		ST_RF2,
		ST_RF3,
		ST_SCAN,
		ST_CMP,
		ST_SHIFT,
		ST_SHW,
		ST_PLACE,
		ST_LOAD,
		ST_GCLR,
		ST_GRF,
		ST_GRF2,
		ST_GNEXT,
		ST_GRD,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] num;
	} div_req_t;

endpackage

>>> rtl/two_choice_bucket_hash_table.sv
// Each item runs two divisions on the shared divider, then scans the slots of its two
// buckets; a remove that hits shifts the later slots of that bucket down.
// An insert that trips the load limit adds a growth pass that clears the spare fill bank,
// then rehashes every stored pair into the spare banks, all paced by the shared divider.
// One item at a time; results wait in an output register. After reset the fill table
// is cleared, during which no item is accepted.
module two_choice_bucket_hash_table import tcbh_pkg::*; #(
	parameter int MAX_BUCKETS  = 1024,
	parameter int BUCKET_DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic [KEY_W-1:0]         key,
	input  logic signed [VAL_W-1:0]  data_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic [USED_W-1:0]        bucket_used,
	output logic [CNTO_W-1:0]        entry_count,
	output logic [CAPO_W-1:0]        capacity_now,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int BKT_W  = $clog2(MAX_BUCKETS);
	localparam int CAP_W  = $clog2(MAX_BUCKETS + 1);
	localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
	localparam int SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int CNT_W  = $clog2(MAX_BUCKETS * BUCKET_DEPTH + 1);
	localparam int PA_W   = 1 + BKT_W + SLOT_W;
	localparam int FA_W   = 1 + BKT_W;
	localparam int LW     = ((CNT_W + 8) > (LOAD_W + CAP_W)) ? (CNT_W + 8) : (LOAD_W + CAP_W);
	localparam logic [CAP_W-1:0]  MAX_CAP = CAP_W'(MAX_BUCKETS);
	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(BUCKET_DEPTH);
	localparam logic [BKT_W-1:0]  LAST_B  = BKT_W'(MAX_BUCKETS - 1);

	function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAPO_W-1:0] v);
		logic [CAP_W-1:0] r;
		if (v == '0) begin
			r = CAP_W'(1);
		end else if (32'(v) > MAX_BUCKETS) begin
			r = MAX_CAP;
		end else begin
			r = CAP_W'(v);
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic               bank_q;
	logic               gmode_q;
	logic [BKT_W-1:0]   clr_q;
	logic [CAP_W-1:0]   cap_q;
	logic [CAP_W-1:0]   gcap_q;
	logic [CNT_W-1:0]   count_q;
	logic [LOAD_W-1:0]  load_q;
	logic               out_valid_q;

	logic               kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [BKT_W-1:0]   b1_q, b2_q, bkt_q, used_q;
	logic [FILL_W-1:0]  f1_q, f2_q, slot_q;
	logic               which_q;
	logic [STAT_W-1:0]  status_q;
	logic [STAT_W-1:0]  status_o_q;
	logic [BKT_W-1:0]   used_o_q;
	logic [CNT_W-1:0]   count_o_q;
	logic [CAP_W-1:0]   cap_o_q;

	logic               p_we, f_we;
	logic [PA_W-1:0]    p_waddr, p_raddr;
	logic [PAIR_W-1:0]  p_wdata, p_rdata;
	logic [FA_W-1:0]    f_waddr, f_raddr;
	logic [FILL_W-1:0]  f_wdata, f_rdata;

	div_req_t           div_req;
	logic [CAP_W-1:0]   div_den;
	logic               div_done;
	logic [KEY_W-1:0]   div_quo;
	logic [CAP_W-1:0]   div_rem;

	logic [BKT_W-1:0]   cb, tb;
	logic [FILL_W-1:0]  cf, tf, slot_dec;
	logic [FILL_W:0]    slot_inc;
	logic               fbank, hit, full, over, last_bkt, clr_done, gclr_done;
	logic [LW-1:0]      load_lhs, load_rhs;
	logic [CAP_W:0]     cap_dbl;

	assign cb        = which_q ? b2_q : b1_q;
	assign cf        = which_q ? f2_q : f1_q;
	assign fbank     = gmode_q ? ~bank_q : bank_q;
	assign slot_inc  = {1'b0, slot_q} + 1'b1;
	assign slot_dec  = slot_q - 1'b1;
	assign hit       = p_rdata[PAIR_W-1:VAL_W] == key_q;
	assign last_bkt  = bkt_q == BKT_W'(cap_q - 1'b1);
	assign clr_done  = clr_q == LAST_B;
	assign gclr_done = clr_q == LAST_B;
	assign load_lhs  = LW'({count_q, 8'h00});
	assign load_rhs  = LW'(load_q) * LW'(cap_q);
	assign over      = (load_lhs > load_rhs) && (cap_q < MAX_CAP);
	assign cap_dbl   = {cap_q, 1'b0};

	always_comb begin
		if (f1_q == '0) begin
			tb = b1_q;
			tf = f1_q;
		end else if (f2_q == '0) begin
			tb = b2_q;
			tf = f2_q;
		end else if (f1_q <= f2_q) begin
			tb = b1_q;
			tf = f1_q;
		end else begin
			tb = b2_q;
			tf = f2_q;
		end
	end
	assign full = tf >= DEPTH_F;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_DIV1;
			ST_DIV1:  if (div_done) state_d = ST_DIV2;
			ST_DIV2:  if (div_done) state_d = ST_RF1;
			ST_RF1:   state_d = ST_RF2;
			ST_RF2:   state_d = ST_RF3;
			ST_RF3:   state_d = gmode_q ? ST_PLACE : ST_SCAN;
			ST_SCAN: begin
				if (slot_q < cf) begin
					state_d = ST_CMP;
				end else if (which_q) begin
					state_d = (kind_q == KIND_INSERT) ? ST_PLACE : ST_RESP;
				end
			end
			ST_CMP: begin
				if (hit) begin
					state_d = (kind_q == KIND_INSERT) ? ST_RESP : ST_SHIFT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SHIFT: state_d = (slot_inc < {1'b0, cf}) ? ST_SHW : ST_RESP;
			ST_SHW:   state_d = ST_SHIFT;
			ST_PLACE: begin
				if (full) begin
					state_d = ST_RESP;
				end else begin
					state_d = gmode_q ? ST_GNEXT : ST_LOAD;
				end
			end
			ST_LOAD:  state_d = over ? ST_GCLR : ST_RESP;
			ST_GCLR:  if (gclr_done) state_d = ST_GRF;
			ST_GRF:   state_d = ST_GRF2;
			ST_GRF2:  state_d = ST_GNEXT;
			ST_GNEXT: begin
				if (slot_q != '0) begin
					state_d = ST_GRD;
				end else begin
					state_d = last_bkt ? ST_RESP : ST_GRF;
				end
			end
			ST_GRD:   state_d = ST_DIV1;
			ST_RESP:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = key;
		div_den       = cap_q;
		p_we          = 1'b0;
		p_waddr       = '0;
		p_wdata       = {key_q, val_q};
		p_raddr       = '0;
		f_we          = 1'b0;
		f_waddr       = '0;
		f_wdata       = '0;
		f_raddr       = '0;
		case (state_q)
			ST_CLEAR: begin
				f_we    = 1'b1;
				f_waddr = {1'b0, clr_q};
			end
			ST_IDLE: begin
				in_ready      = 1'b1;
				div_req.start = in_valid;
			end
			ST_DIV1: begin
				div_req.start = div_done;
				div_req.num   = div_quo;
				div_den       = gmode_q ? gcap_q : cap_q;
			end
			ST_RF1: f_raddr = {fbank, b1_q};
			ST_RF2: f_raddr = {fbank, b2_q};
			ST_SCAN: p_raddr = {bank_q, cb, slot_q[SLOT_W-1:0]};
			ST_SHIFT: begin
				if (slot_inc < {1'b0, cf}) begin
					p_raddr = {bank_q, cb, slot_inc[SLOT_W-1:0]};
				end else begin
					f_we    = 1'b1;
					f_waddr = {bank_q, cb};
					f_wdata = cf - 1'b1;
				end
			end
			ST_SHW: begin
				p_we    = 1'b1;
				p_waddr = {bank_q, cb, slot_q[SLOT_W-1:0]};
				p_wdata = p_rdata;
			end
			ST_PLACE: begin
				if (!full) begin
					p_we    = 1'b1;
					p_waddr = {fbank, tb, tf[SLOT_W-1:0]};
					f_we    = 1'b1;
					f_waddr = {fbank, tb};
					f_wdata = tf + 1'b1;
				end
			end
			ST_GCLR: begin
				f_we    = 1'b1;
				f_waddr = {~bank_q, clr_q};
			end
			ST_GRF:   f_raddr = {bank_q, bkt_q};
			ST_GNEXT: p_raddr = {bank_q, bkt_q, slot_dec[SLOT_W-1:0]};
			ST_GRD: begin
				div_req.start = 1'b1;
				div_req.num   = p_rdata[PAIR_W-1:VAL_W];
				div_den       = gcap_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			bank_q      <= 1'b0;
			gmode_q     <= 1'b0;
			clr_q       <= '0;
			cap_q       <= clamp_cap(CAPO_W'(INIT_CAP_RST));
			count_q     <= '0;
			load_q      <= LOAD_W'(LOAD_MAX_RST);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_INIT_CAP) begin
					if (count_q == '0) begin
						cap_q <= clamp_cap(cfg_data[CAPO_W-1:0]);
					end
				end else if (cfg_index == CFG_LOAD_MAX) begin
					load_q <= cfg_data;
				end
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE:  if (in_valid) gmode_q <= 1'b0;
				ST_SHIFT: if (!(slot_inc < {1'b0, cf})) count_q <= count_q - 1'b1;
				ST_PLACE: if (!full && !gmode_q) count_q <= count_q + 1'b1;
				ST_LOAD: begin
					clr_q <= '0;
					if (over) gmode_q <= 1'b1;
				end
				ST_GCLR:  clr_q <= clr_q + 1'b1;
				ST_GNEXT: begin
					if (slot_q == '0 && last_bkt) begin
						bank_q <= ~bank_q;
						cap_q  <= gcap_q;
					end
				end
				ST_RESP:  if (!out_valid_q || out_ready) out_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q   <= kind;
				key_q    <= key;
				val_q    <= data_value;
				status_q <= STAT_NOT_FOUND;
				used_q   <= '0;
			end
			ST_DIV1: if (div_done) b1_q <= BKT_W'(div_rem);
			ST_DIV2: if (div_done) b2_q <= BKT_W'(div_rem);
			ST_RF2:  f1_q <= f_rdata;
			ST_RF3: begin
				f2_q    <= f_rdata;
				which_q <= 1'b0;
				if (!gmode_q) slot_q <= '0;
			end
			ST_SCAN: begin
				if (!(slot_q < cf) && !which_q) begin
					which_q <= 1'b1;
					slot_q  <= '0;
				end
			end
			ST_CMP: begin
				if (hit) begin
					if (kind_q == KIND_INSERT) status_q <= STAT_DUPLICATE;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			ST_SHIFT: begin
				if (!(slot_inc < {1'b0, cf})) begin
					status_q <= STAT_REMOVED;
					used_q   <= cb;
				end
			end
			ST_SHW: slot_q <= slot_q + 1'b1;
			ST_PLACE: begin
				if (!gmode_q) begin
					if (full) begin
						status_q <= STAT_FULL;
					end else begin
						status_q <= STAT_INSERTED;
						used_q   <= tb;
					end
				end
			end
			ST_LOAD: begin
				gcap_q <= (cap_dbl > {1'b0, MAX_CAP}) ? MAX_CAP : cap_dbl[CAP_W-1:0];
				bkt_q  <= '0;
			end
			ST_GRF2: slot_q <= f_rdata;
			ST_GNEXT: begin
				if (slot_q != '0) begin
					slot_q <= slot_dec;
				end else if (!last_bkt) begin
					bkt_q <= bkt_q + 1'b1;
				end
			end
			ST_GRD: begin
				key_q <= p_rdata[PAIR_W-1:VAL_W];
				val_q <= p_rdata[VAL_W-1:0];
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					status_o_q <= status_q;
					used_o_q   <= used_q;
					count_o_q  <= count_q;
					cap_o_q    <= cap_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = status_o_q;
	assign bucket_used  = USED_W'(used_o_q);
	assign entry_count  = CNTO_W'(count_o_q);
	assign capacity_now = CAPO_W'(cap_o_q);

	tcbh_div #(
		.DEN_W(CAP_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	tcbh_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(2 ** PA_W)
	) u_pair_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	tcbh_ram #(
		.WIDTH(FILL_W),
		.DEPTH(2 ** FA_W)
	) u_fill_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	property p_busy_after_accept;
		@(posedge clk) disable iff (!arst_n) (in_valid && in_ready) |=> !in_ready;
	endproperty
	a_busy_after_accept: assert property (p_busy_after_accept)
		else $error("item accepted while previous item still at work");

	property p_cap_range;
		@(posedge clk) disable iff (!arst_n) (cap_q != '0) && (cap_q <= MAX_CAP);
	endproperty
	a_cap_range: assert property (p_cap_range)
		else $error("capacity out of range");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_IDLE) |-> (32'(count_q) <= 32'(cap_q) * BUCKET_DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("entry count exceeds table space");

	property p_grow_flip;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_GNEXT && slot_q == '0 && last_bkt) |=>
			(bank_q != $past(bank_q)) && (cap_q == $past(gcap_q));
	endproperty
	a_grow_flip: assert property (p_grow_flip)
		else $error("growth finished without switching bank and capacity");

endmodule

>>> rtl/tcbh_ram.sv
module tcbh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tcbh_div.sv
module tcbh_div import tcbh_pkg::*; #(
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [KEY_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(KEY_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   partial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign partial = {rem_q, num_q[KEY_W-1]};
	assign ge      = partial >= {1'b0, den_q};
	assign diff    = partial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(KEY_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[KEY_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy)
		else $error("divider done without a running division");

	property p_rem_below_den;
		@(posedge clk) disable iff (!arst_n) done_q |-> (rem_q < den_q);
	endproperty
	a_rem_below_den: assert property (p_rem_below_den)
		else $error("divider remainder not below divisor");

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !req.start;
	endproperty
	a_no_restart: assert property (p_no_restart)
		else $error("divider restarted while busy");

endmodule
